[src/kvlp_pkg.sv]
// Shared types, codes and defaults for the key/value line parser.
package kvlp_pkg;

	// Default depth of the held whitespace store
	localparam int HELD_SPACE_DEPTH_DEF = 32;

	// Character codes
	localparam logic [7:0] CH_EQUALS  = 8'h3d;
	localparam logic [7:0] CH_PERCENT = 8'h25;
	localparam logic [7:0] CH_NUL     = 8'h00;

	// Result kind codes
	localparam logic [1:0] KIND_NAME  = 2'd0;
	localparam logic [1:0] KIND_VALUE = 2'd1;
	localparam logic [1:0] KIND_END   = 2'd2;

	// Line status codes on the end marker
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NO_EQ    = 2'd1;
	localparam logic [1:0] ST_OVERFLOW = 2'd2;

	// Sequencer phases, in emission order
	typedef enum logic [3:0] {
		PH_IDLE,
		PH_PRE_PCT,
		PH_PRE_HEX,
		PH_FLUSH_RD,
		PH_FLUSH_EMIT,
		PH_MAIN,
		PH_TAIL_PCT,
		PH_TAIL_HEX,
		PH_MARKER
	} phase_t;

	// Which results one input byte produces
	typedef struct packed {
		logic pre_pct;
		logic pre_hex;
		logic flush;
		logic main;
		logic tail_pct;
		logic tail_hex;
		logic marker;
	} plan_t;

	// Controller to datapath
	typedef struct packed {
		logic   load;
		logic   mem_rd;
		logic   emit;
		logic   idx_inc;
		logic   last;
		phase_t src;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		plan_t plan_c;
		plan_t plan_q;
		logic  flush_last;
		logic  out_free;
	} sts_t;

endpackage

[src/kvlp_dp.sv]
// Datapath of the key/value line parser: parse state, whitespace store, output register.
module kvlp_dp #(
	parameter int HELD_SPACE_DEPTH = kvlp_pkg::HELD_SPACE_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [7:0]        in_byte,
	input  logic              end_of_line,
	input  kvlp_pkg::cmd_t    cmd,
	output kvlp_pkg::sts_t    sts,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [7:0]        out_byte,
	output logic [1:0]        field_kind,
	output logic [1:0]        line_status,
	output logic              last_of_run
);
	import kvlp_pkg::*;

	localparam int CNT_W = $clog2(HELD_SPACE_DEPTH + 1);
	localparam int IDX_W = (HELD_SPACE_DEPTH > 1) ? $clog2(HELD_SPACE_DEPTH) : 1;

	typedef enum logic [1:0] {
		MODE_NAME_LEAD,
		MODE_NAME,
		MODE_VALUE_LEAD,
		MODE_VALUE
	} mode_t;

	typedef enum logic [1:0] {
		ESC_NONE,
		ESC_PCT,
		ESC_HEX1
	} esc_t;

	function automatic logic is_ws(input logic [7:0] b);
		return (b == 8'h20) || (b >= 8'h09 && b <= 8'h0d);
	endfunction

	function automatic logic is_hex(input logic [7:0] b);
		return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h61 && b <= 8'h66) ||
			(b >= 8'h41 && b <= 8'h46);
	endfunction

	// Letters carry their value minus 9 in the low nibble
	function automatic logic [3:0] hex_val(input logic [7:0] b);
		return (b <= 8'h39) ? b[3:0] : (b[3:0] + 4'd9);
	endfunction

	mode_t            mode_q, nxt_mode;
	esc_t             esc_q, nxt_esc;
	logic [7:0]       fh_q, nxt_fh;
	logic [CNT_W-1:0] cnt_q;
	logic             ovf_q, nxt_ovf;

	logic [7:0]       mem [HELD_SPACE_DEPTH];
	logic [7:0]       rd_data_q;
	logic [CNT_W-1:0] flush_n_q, idx_q;

	plan_t            plan_c, plan_q;
	logic [7:0]       pre_hex_q, main_byte_q, tail_hex_q;
	logic             kind_val_q;
	logic [1:0]       status_q;

	logic             out_valid_q, out_last_q;
	logic [7:0]       out_byte_q;
	logic [1:0]       out_kind_q, out_status_q;

	logic             ws, hex, eq, pct;
	logic             do_hold, do_flush, do_clr, do_vp, do_wr;
	logic [7:0]       main_byte;
	logic             kind_val;
	logic [1:0]       status_c;

	// Decode the incoming byte against the current parse state
	always_comb begin
		ws        = is_ws(in_byte);
		hex       = is_hex(in_byte);
		eq        = (in_byte == CH_EQUALS);
		pct       = (in_byte == CH_PERCENT);
		nxt_mode  = mode_q;
		nxt_esc   = esc_q;
		nxt_fh    = fh_q;
		nxt_ovf   = ovf_q;
		plan_c    = '0;
		do_hold   = 1'b0;
		do_flush  = 1'b0;
		do_clr    = 1'b0;
		do_vp     = 1'b0;
		do_wr     = 1'b0;
		main_byte = in_byte;
		case (mode_q)
			MODE_NAME_LEAD: begin
				if (eq) begin
					nxt_mode = MODE_VALUE_LEAD;
				end else if (!ws) begin
					nxt_mode    = MODE_NAME;
					plan_c.main = 1'b1;
				end
			end
			MODE_NAME: begin
				if (eq) begin
					do_clr   = 1'b1;
					nxt_mode = MODE_VALUE_LEAD;
				end else if (ws) begin
					do_hold = 1'b1;
				end else begin
					do_flush    = 1'b1;
					plan_c.main = 1'b1;
				end
			end
			MODE_VALUE_LEAD: begin
				if (!ws) begin
					nxt_mode = MODE_VALUE;
					do_vp    = 1'b1;
				end
			end
			MODE_VALUE: begin
				case (esc_q)
					ESC_PCT: begin
						if (hex) begin
							nxt_fh  = in_byte;
							nxt_esc = ESC_HEX1;
						end else begin
							plan_c.pre_pct = 1'b1;
							nxt_esc        = ESC_NONE;
							do_vp          = 1'b1;
						end
					end
					ESC_HEX1: begin
						nxt_esc = ESC_NONE;
						if (hex) begin
							plan_c.main = 1'b1;
							main_byte   = {hex_val(fh_q), hex_val(in_byte)};
						end else begin
							plan_c.pre_pct = 1'b1;
							plan_c.pre_hex = 1'b1;
							do_vp          = 1'b1;
						end
					end
					default: do_vp = 1'b1;
				endcase
			end
			default: ;
		endcase

		// Ordinary value byte
		if (do_vp) begin
			if (ws) begin
				do_hold = 1'b1;
			end else if (pct) begin
				do_flush = 1'b1;
				nxt_esc  = ESC_PCT;
			end else begin
				do_flush    = 1'b1;
				plan_c.main = 1'b1;
			end
		end

		// Hold whitespace, or drop it when the store is full
		if (do_hold) begin
			if (cnt_q == CNT_W'(HELD_SPACE_DEPTH)) nxt_ovf = 1'b1;
			else do_wr = 1'b1;
		end

		plan_c.flush    = do_flush && (cnt_q != '0);
		plan_c.tail_pct = end_of_line && (nxt_mode == MODE_VALUE) && (nxt_esc != ESC_NONE);
		plan_c.tail_hex = end_of_line && (nxt_mode == MODE_VALUE) && (nxt_esc == ESC_HEX1);
		plan_c.marker   = end_of_line;
		kind_val        = (nxt_mode == MODE_VALUE_LEAD) || (nxt_mode == MODE_VALUE);
		if (!kind_val) status_c = ST_NO_EQ;
		else if (nxt_ovf) status_c = ST_OVERFLOW;
		else status_c = ST_OK;
	end

	// Parse state and result plan; the end of a line returns the parse state to reset values
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_NAME_LEAD;
			esc_q  <= ESC_NONE;
			fh_q   <= '0;
			cnt_q  <= '0;
			ovf_q  <= 1'b0;
			plan_q <= '0;
		end else if (cmd.load) begin
			plan_q <= plan_c;
			if (end_of_line) begin
				mode_q <= MODE_NAME_LEAD;
				esc_q  <= ESC_NONE;
				fh_q   <= '0;
				cnt_q  <= '0;
				ovf_q  <= 1'b0;
			end else begin
				mode_q <= nxt_mode;
				esc_q  <= nxt_esc;
				fh_q   <= nxt_fh;
				ovf_q  <= nxt_ovf;
				if (do_flush || do_clr) cnt_q <= '0;
				else if (do_wr) cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end

	// Per-item payload captured at the transfer
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			flush_n_q   <= cnt_q;
			pre_hex_q   <= fh_q;
			main_byte_q <= main_byte;
			tail_hex_q  <= nxt_fh;
			kind_val_q  <= kind_val;
			status_q    <= status_c;
		end
	end

	// Flush index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (cmd.load) begin
			idx_q <= '0;
		end else if (cmd.idx_inc) begin
			idx_q <= idx_q + CNT_W'(1);
		end
	end

	// Held whitespace store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (cmd.load && do_wr) mem[cnt_q[IDX_W-1:0]] <= in_byte;
		if (cmd.mem_rd) rd_data_q <= mem[idx_q[IDX_W-1:0]];
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_last_q   <= cmd.last;
			out_status_q <= ST_OK;
			out_kind_q   <= KIND_VALUE;
			case (cmd.src)
				PH_PRE_PCT:    out_byte_q <= CH_PERCENT;
				PH_PRE_HEX:    out_byte_q <= pre_hex_q;
				PH_TAIL_PCT:   out_byte_q <= CH_PERCENT;
				PH_TAIL_HEX:   out_byte_q <= tail_hex_q;
				PH_FLUSH_EMIT: begin
					out_byte_q <= rd_data_q;
					out_kind_q <= kind_val_q ? KIND_VALUE : KIND_NAME;
				end
				PH_MAIN: begin
					out_byte_q <= main_byte_q;
					out_kind_q <= kind_val_q ? KIND_VALUE : KIND_NAME;
				end
				default: begin
					out_byte_q   <= CH_NUL;
					out_kind_q   <= KIND_END;
					out_status_q <= status_q;
				end
			endcase
		end
	end

	assign sts.plan_c     = plan_c;
	assign sts.plan_q     = plan_q;
	assign sts.flush_last = (idx_q == flush_n_q - CNT_W'(1));
	assign sts.out_free   = !out_valid_q || out_ready;

	assign out_valid   = out_valid_q;
	assign out_byte    = out_byte_q;
	assign field_kind  = out_kind_q;
	assign line_status = out_status_q;
	assign last_of_run = out_last_q;

endmodule

[src/kvlp_ctrl.sv]
// Controller of the key/value line parser: sequences the results of one input byte.
module kvlp_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  kvlp_pkg::sts_t sts,
	output kvlp_pkg::cmd_t cmd
);
	import kvlp_pkg::*;

	phase_t state_q, state_d;

	// First pending phase strictly after the given one
	function automatic phase_t after(input plan_t p, input phase_t from);
		phase_t r;
		r = PH_IDLE;
		if (p.marker   && from < PH_MARKER)   r = PH_MARKER;
		if (p.tail_hex && from < PH_TAIL_HEX) r = PH_TAIL_HEX;
		if (p.tail_pct && from < PH_TAIL_PCT) r = PH_TAIL_PCT;
		if (p.main     && from < PH_MAIN)     r = PH_MAIN;
		if (p.flush    && from < PH_FLUSH_RD) r = PH_FLUSH_RD;
		if (p.pre_hex  && from < PH_PRE_HEX)  r = PH_PRE_HEX;
		if (p.pre_pct  && from < PH_PRE_PCT)  r = PH_PRE_PCT;
		return r;
	endfunction

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			PH_IDLE: begin
				if (in_valid) state_d = after(sts.plan_c, PH_IDLE);
			end
			PH_FLUSH_RD: state_d = PH_FLUSH_EMIT;
			PH_FLUSH_EMIT: begin
				if (sts.out_free) begin
					state_d = sts.flush_last ? after(sts.plan_q, PH_FLUSH_EMIT) : PH_FLUSH_RD;
				end
			end
			PH_PRE_PCT, PH_PRE_HEX, PH_MAIN, PH_TAIL_PCT, PH_TAIL_HEX, PH_MARKER: begin
				if (sts.out_free) state_d = after(sts.plan_q, state_q);
			end
			default: state_d = PH_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		cmd      = '0;
		cmd.src  = state_q;
		in_ready = 1'b0;
		case (state_q)
			PH_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			PH_FLUSH_RD: cmd.mem_rd = 1'b1;
			PH_FLUSH_EMIT: begin
				cmd.emit    = sts.out_free;
				cmd.idx_inc = sts.out_free;
				cmd.last    = sts.flush_last && (after(sts.plan_q, PH_FLUSH_EMIT) == PH_IDLE);
			end
			PH_PRE_PCT, PH_PRE_HEX, PH_MAIN, PH_TAIL_PCT, PH_TAIL_HEX, PH_MARKER: begin
				cmd.emit = sts.out_free;
				cmd.last = (after(sts.plan_q, state_q) == PH_IDLE);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= PH_IDLE;
		else state_q <= state_d;
	end

endmodule

[src/key_value_line_parser.sv]
// Key/value line parser top level: stream ports, controller and datapath.
//
// Takes a text line one byte per transfer and returns it split at the first
// '=' into name bytes and value bytes, with leading and trailing whitespace of
// both parts removed and %XX escapes in the value decoded; a final marker
// result carries the line status (ok, no '=', whitespace store overflowed).
// An input byte is taken in while the controller is idle; its results, if
// any, are then sent in order, each when the output register is free, and
// each held whitespace byte flushed is first read from the HELD_SPACE_DEPTH
// byte store through its registered read port and then sent.
// The controller handles one input byte at a time; the output register lets
// a finished result wait while the next byte is taken in. No clearing pass
// after reset.
module key_value_line_parser #(
	parameter int HELD_SPACE_DEPTH = kvlp_pkg::HELD_SPACE_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
	input  logic       s_axis_tlast,   // end_of_line
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,   // [7:0] out_byte
	output logic [3:0] m_axis_tuser,   // [1:0] field_kind, [3:2] line_status
	output logic       m_axis_tlast    // last_of_run
);
	import kvlp_pkg::*;

	cmd_t cmd;
	sts_t sts;

	kvlp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	kvlp_dp #(
		.HELD_SPACE_DEPTH (HELD_SPACE_DEPTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_byte     (s_axis_tdata),
		.end_of_line (s_axis_tlast),
		.cmd         (cmd),
		.sts         (sts),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.out_byte    (m_axis_tdata),
		.field_kind  (m_axis_tuser[1:0]),
		.line_status (m_axis_tuser[3:2]),
		.last_of_run (m_axis_tlast)
	);

endmodule

[src/kvlp_checker.sv]
// Port-level checks for the key/value line parser, bound to its top level.
module kvlp_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       s_axis_tvalid,
	input logic       s_axis_tready,
	input logic [7:0] s_axis_tdata,
	input logic       s_axis_tlast,
	input logic       m_axis_tvalid,
	input logic       m_axis_tready,
	input logic [7:0] m_axis_tdata,
	input logic [3:0] m_axis_tuser,
	input logic       m_axis_tlast
);
	import kvlp_pkg::*;

	// End marker is a zero byte and closes its run
	a_marker: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser[1:0] == KIND_END) |->
			(m_axis_tdata == CH_NUL) && m_axis_tlast)
		else $error("end marker with data or without last");

	// Data results carry status ok
	a_data_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser[1:0] != KIND_END) |-> (m_axis_tuser[3:2] == ST_OK))
		else $error("data result with nonzero status");

	// No kind or status code beyond the defined ones
	a_codes: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tuser[1:0] != 2'd3) && (m_axis_tuser[3:2] != 2'd3))
		else $error("undefined kind or status code");

	// A stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
			$stable(m_axis_tlast))
		else $error("stalled result changed");

endmodule

bind key_value_line_parser kvlp_checker u_kvlp_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tdata  (s_axis_tdata),
	.s_axis_tlast  (s_axis_tlast),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser),
	.m_axis_tlast  (m_axis_tlast)
);
